// File: rtl/mrope_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes of the multimodal rotary position id generator.
package mrope_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QADDR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int POS_W      = 20;
  localparam int TOKEN_W    = 18;
  localparam int GT_W       = 3;
  localparam int GHW_W      = 10;
  localparam int MSHIFT_W   = 2;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;
  localparam int GRID_W     = GT_W + 2 * GHW_W;

  localparam logic [MSHIFT_W-1:0] MERGE_SHIFT_RST = MSHIFT_W'(1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PROMPT  = 2'd0,
    REQ_PUSH    = 2'd1,
    REQ_NEW_SEQ = 2'd2,
    REQ_GEN     = 2'd3
  } req_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_GRID    = 2'd1,
    ST_QUEUE_FULL = 2'd2,
    ST_SATURATED  = 2'd3
  } status_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VISION_START_ID = 1'b0,
    CFG_MERGE_SHIFT     = 1'b1
  } cfg_idx_e_t;

  typedef struct packed {
    logic [GT_W-1:0]  t;
    logic [GHW_W-1:0] h;
    logic [GHW_W-1:0] w;
  } grid_t;

  typedef struct packed {
    logic [POS_W-1:0]    pos_t;
    logic [POS_W-1:0]    pos_h;
    logic [POS_W-1:0]    pos_w;
    logic                is_visual;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// File: rtl/mrope_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module mrope_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mrope_out_buf.sv
`timescale 1ns / 1ps
// Output register with a skid entry, so that the input side can still hand over one result while the output stalls.
module mrope_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  mrope_pkg::result_t res,
  output logic              res_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mrope_pkg::result_t out_res
);
  import mrope_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_res_r, out_res_nxt;
  result_t skid_res_r, skid_res_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_res_nxt   = res;
      end
    end else if (res_valid) begin
      // The output register is held, so the new transaction parks in the skid entry.
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign res_ready = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/mrope_position_id_generator_top.sv
`timescale 1ns / 1ps
// Top level of the multimodal rotary position id generator.
// A result is registered in the output buffer, in its skid entry while out_* stalls.
// Throughput: one item per cycle while the skid entry is free; the grid RAM read port
// reads the head each cycle; a bypass covers a grid written the cycle before its pop.
// Reset clears positions, span state, queue pointers and configuration (merge shift 1);
// the grid RAM contents are not cleared and only written entries are ever popped.
module mrope_position_id_generator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mrope_pkg::REQ_W-1:0]         in_req_type,
  input  logic [mrope_pkg::TOKEN_W-1:0]       in_token_id,
  input  logic [mrope_pkg::GT_W-1:0]          in_grid_t,
  input  logic [mrope_pkg::GHW_W-1:0]         in_grid_h,
  input  logic [mrope_pkg::GHW_W-1:0]         in_grid_w,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mrope_pkg::POS_W-1:0]         out_pos_t,
  output logic [mrope_pkg::POS_W-1:0]         out_pos_h,
  output logic [mrope_pkg::POS_W-1:0]         out_pos_w,
  output logic                                out_is_visual,
  output logic [mrope_pkg::STATUS_W-1:0]      out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrope_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrope_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mrope_pkg::*;

  localparam logic [QADDR_W-1:0] LAST_SLOT  = QADDR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0]  FULL_COUNT = QCNT_W'(QUEUE_DEPTH);

  function automatic logic [POS_W:0] sat_add(input logic [POS_W-1:0] a,
                                             input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[POS_W]) begin
      s = {1'b1, {POS_W{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic [GHW_W-1:0] max3(input logic [GT_W-1:0] a,
                                            input logic [GHW_W-1:0] b,
                                            input logic [GHW_W-1:0] c);
    logic [GHW_W-1:0] m;
    m = GHW_W'(a);
    if (b > m) begin
      m = b;
    end
    if (c > m) begin
      m = c;
    end
    return m;
  endfunction

  function automatic logic [QADDR_W-1:0] ptr_inc(input logic [QADDR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + QADDR_W'(1);
  endfunction

  // Configuration.
  logic [TOKEN_W-1:0]  vision_start_id_r;
  logic [MSHIFT_W-1:0] merge_shift_r;

  // Sequence and queue state.
  logic [QADDR_W-1:0] head_r, head_nxt;
  logic [QADDR_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]   base_r, base_nxt;
  logic [POS_W-1:0]   run_r, run_nxt;
  logic               vis_r, vis_nxt;
  grid_t              dims_r, dims_nxt;
  grid_t              cnt_r, cnt_nxt;

  // Grid RAM and its head bypass.
  logic               ram_we;
  logic [GRID_W-1:0]  ram_rdata;
  grid_t              push_grid;
  logic               fwd_r;
  grid_t              fwd_data_r;
  grid_t              head_grid;

  // Datapath.
  logic               in_fire;
  logic               res_valid;
  result_t            res;
  logic [POS_W:0]     b_sum, b_plus1, run_inc, close_cur, pop_close;
  logic [POS_W:0]     vt_sum, vh_sum, vw_sum;
  logic [GHW_W-1:0]   g_h, g_w;
  logic [GHW_W:0]     w1, h1;
  logic [GT_W:0]      t1;
  grid_t              cnt_step;
  logic               span_done;
  logic               vis_sat;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign push_grid = '{t: in_grid_t, h: in_grid_h, w: in_grid_w};
  assign head_grid = fwd_r ? fwd_data_r : grid_t'(ram_rdata);

  assign b_sum     = sat_add(base_r, run_r);
  assign b_plus1   = sat_add(b_sum[POS_W-1:0], POS_W'(1));
  assign run_inc   = sat_add(run_r, POS_W'(1));
  assign close_cur = sat_add(b_sum[POS_W-1:0], POS_W'(max3(dims_r.t, dims_r.h, dims_r.w)));

  assign g_h       = head_grid.h >> merge_shift_r;
  assign g_w       = head_grid.w >> merge_shift_r;
  assign pop_close = sat_add(b_plus1[POS_W-1:0], POS_W'(max3(head_grid.t, g_h, g_w)));

  assign vt_sum  = sat_add(b_sum[POS_W-1:0], POS_W'(cnt_r.t));
  assign vh_sum  = sat_add(b_sum[POS_W-1:0], POS_W'(cnt_r.h));
  assign vw_sum  = sat_add(b_sum[POS_W-1:0], POS_W'(cnt_r.w));
  assign vis_sat = b_sum[POS_W] | vt_sum[POS_W] | vh_sum[POS_W] | vw_sum[POS_W];

  // Span walk in t, h, w order with w fastest.
  assign w1 = {1'b0, cnt_r.w} + (GHW_W + 1)'(1);
  assign h1 = {1'b0, cnt_r.h} + (GHW_W + 1)'(1);
  assign t1 = {1'b0, cnt_r.t} + (GT_W + 1)'(1);

  always_comb begin
    cnt_step  = cnt_r;
    span_done = 1'b0;
    if (w1 >= {1'b0, dims_r.w}) begin
      cnt_step.w = '0;
      if (h1 >= {1'b0, dims_r.h}) begin
        cnt_step.h = '0;
        if (t1 >= {1'b0, dims_r.t}) begin
          span_done = 1'b1;
        end else begin
          cnt_step.t = t1[GT_W-1:0];
        end
      end else begin
        cnt_step.h = h1[GHW_W-1:0];
      end
    end else begin
      cnt_step.w = w1[GHW_W-1:0];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    base_nxt  = base_r;
    run_nxt   = run_r;
    vis_nxt   = vis_r;
    dims_nxt  = dims_r;
    cnt_nxt   = cnt_r;
    ram_we    = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    if (in_fire) begin
      case (req_e_t'(in_req_type))
        REQ_PUSH: begin
          if (count_r >= FULL_COUNT) begin
            res_valid  = 1'b1;
            res.status = ST_QUEUE_FULL;
          end else begin
            ram_we    = 1'b1;
            tail_nxt  = ptr_inc(tail_r);
            count_nxt = count_r + QCNT_W'(1);
          end
        end
        REQ_NEW_SEQ: begin
          base_nxt = '0;
          run_nxt  = '0;
          vis_nxt  = 1'b0;
          dims_nxt = '0;
          cnt_nxt  = '0;
        end
        REQ_GEN: begin
          res_valid = 1'b1;
          if (vis_r) begin
            // The open span is abandoned: the base moves past it first.
            base_nxt      = close_cur[POS_W-1:0];
            run_nxt       = POS_W'(1);
            vis_nxt       = 1'b0;
            cnt_nxt       = '0;
            res.pos_t     = close_cur[POS_W-1:0];
            res.pos_h     = close_cur[POS_W-1:0];
            res.pos_w     = close_cur[POS_W-1:0];
            res.status    = ST_OK;
          end else begin
            run_nxt    = run_inc[POS_W-1:0];
            res.pos_t  = b_sum[POS_W-1:0];
            res.pos_h  = b_sum[POS_W-1:0];
            res.pos_w  = b_sum[POS_W-1:0];
            res.status = b_sum[POS_W] ? ST_SATURATED : ST_OK;
          end
        end
        REQ_PROMPT: begin
          res_valid = 1'b1;
          if (vis_r) begin
            res.pos_t     = vt_sum[POS_W-1:0];
            res.pos_h     = vh_sum[POS_W-1:0];
            res.pos_w     = vw_sum[POS_W-1:0];
            res.is_visual = 1'b1;
            res.status    = vis_sat ? ST_SATURATED : ST_OK;
            if (span_done) begin
              base_nxt = close_cur[POS_W-1:0];
              run_nxt  = '0;
              vis_nxt  = 1'b0;
              cnt_nxt  = '0;
            end else begin
              cnt_nxt = cnt_step;
            end
          end else begin
            run_nxt    = run_inc[POS_W-1:0];
            res.pos_t  = b_sum[POS_W-1:0];
            res.pos_h  = b_sum[POS_W-1:0];
            res.pos_w  = b_sum[POS_W-1:0];
            res.status = b_sum[POS_W] ? ST_SATURATED : ST_OK;
            if (in_token_id == vision_start_id_r) begin
              if (count_r == '0) begin
                res.status = ST_NO_GRID;
              end else begin
                head_nxt  = ptr_inc(head_r);
                count_nxt = count_r - QCNT_W'(1);
                dims_nxt  = '{t: head_grid.t, h: g_h, w: g_w};
                cnt_nxt   = '0;
                if ((head_grid.t == '0) || (g_h == '0) || (g_w == '0)) begin
                  // An empty span closes at once, counting this token in the run.
                  base_nxt = pop_close[POS_W-1:0];
                  run_nxt  = '0;
                end else begin
                  vis_nxt = 1'b1;
                end
              end
            end
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vision_start_id_r <= '0;
      merge_shift_r     <= MERGE_SHIFT_RST;
      head_r            <= '0;
      tail_r            <= '0;
      count_r           <= '0;
      base_r            <= '0;
      run_r             <= '0;
      vis_r             <= 1'b0;
      dims_r            <= '0;
      cnt_r             <= '0;
      fwd_r             <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_e_t'(cfg_index))
          CFG_VISION_START_ID: vision_start_id_r <= cfg_data[TOKEN_W-1:0];
          CFG_MERGE_SHIFT:     merge_shift_r     <= cfg_data[MSHIFT_W-1:0];
          default: begin
            merge_shift_r <= merge_shift_r;
          end
        endcase
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      base_r  <= base_nxt;
      run_r   <= run_nxt;
      vis_r   <= vis_nxt;
      dims_r  <= dims_nxt;
      cnt_r   <= cnt_nxt;
      // A grid written into the slot that becomes the head bypasses the RAM read.
      fwd_r   <= ram_we && (tail_r == head_nxt);
    end
    fwd_data_r <= push_grid;
  end

  mrope_ram #(
    .WIDTH (GRID_W),
    .DEPTH (QUEUE_DEPTH),
    .ADDR_W(QADDR_W)
  ) u_grid_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_r),
    .wdata(push_grid),
    .raddr(head_nxt),
    .rdata(ram_rdata)
  );

  result_t out_res;

  mrope_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_pos_t     = out_res.pos_t;
  assign out_pos_h     = out_res.pos_h;
  assign out_pos_w     = out_res.pos_w;
  assign out_is_visual = out_res.is_visual;
  assign out_status    = out_res.status;

endmodule

// File: sim/mrope_position_id_generator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the multimodal rotary position id generator.
module mrope_position_id_generator_top_tb;
  import mrope_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam int STUCK_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct {
    req_e_t               req;
    logic [TOKEN_W-1:0]   tok;
    grid_t                grid;
  } token_req_t;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  req_e_t                in_req_type   = REQ_PROMPT;
  logic [TOKEN_W-1:0]    in_token_id   = '0;
  logic [GT_W-1:0]       in_grid_t     = GT_W'(1);
  logic [GHW_W-1:0]      in_grid_h     = GHW_W'(1);
  logic [GHW_W-1:0]      in_grid_w     = GHW_W'(1);
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [POS_W-1:0]      out_pos_t;
  logic [POS_W-1:0]      out_pos_h;
  logic [POS_W-1:0]      out_pos_w;
  logic                  out_is_visual;
  logic [STATUS_W-1:0]   out_status;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  cfg_idx_e_t            cfg_index     = CFG_VISION_START_ID;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  mrope_position_id_generator_top u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Requests waiting for the driver, and results predicted but not yet seen.
  token_req_t queued_requests[$];
  result_t    predicted_positions[$];

  bit in_fire, out_fire, cfg_fire;
  bit jitter_on   = 1'b1;
  bit stall_phase = 1'b0;
  int rx_hold_cnt = 0;
  int stuck_cycles = 0;
  int mismatches = 0;

  // Predictor state, mirrors the block after reset.
  grid_t               gq_mem [QUEUE_DEPTH];
  int unsigned         gq_head = 0, gq_count = 0;
  logic [POS_W-1:0]    pos_base = '0, run_len = '0;
  bit                  span_open = 1'b0;
  int unsigned         span_t = 0, span_h = 0, span_w = 0;
  int unsigned         at_t = 0, at_h = 0, at_w = 0;
  logic [TOKEN_W-1:0]  cfg_vs_id = '0;
  logic [MSHIFT_W-1:0] cfg_shift = MERGE_SHIFT_RST;

  // Stimulus-side view: configuration and the grids still queued in the block.
  logic [TOKEN_W-1:0]  plan_vs_id = '0;
  logic [MSHIFT_W-1:0] plan_shift = MERGE_SHIFT_RST;
  grid_t               plan_grids[$];

  function automatic logic [POS_W-1:0] clamp_pos(input longint unsigned v);
    return (v > POS_MAX) ? POS_MAX : POS_W'(v);
  endfunction

  task automatic close_span();
    int unsigned m;
    m = span_t;
    if (span_h > m) m = span_h;
    if (span_w > m) m = span_w;
    pos_base = clamp_pos(longint'(clamp_pos(longint'(pos_base) + run_len)) + m);
    run_len = '0;
    span_open = 1'b0;
    at_t = 0;
    at_h = 0;
    at_w = 0;
  endtask

  task automatic predict_positions(input req_e_t req, input logic [TOKEN_W-1:0] tok,
                                   input grid_t g);
    result_t r;
    longint unsigned sum;
    logic [POS_W-1:0] b;
    bit hit;
    r = '0;
    hit = 1'b0;
    case (req)
      REQ_PUSH: begin
        if (gq_count >= QUEUE_DEPTH) begin
          r.status = ST_QUEUE_FULL;
          predicted_positions.insert(predicted_positions.size(), r);
        end else begin
          gq_mem[(gq_head + gq_count) % QUEUE_DEPTH] = g;
          gq_count++;
        end
      end
      REQ_NEW_SEQ: begin
        pos_base = '0;
        run_len = '0;
        span_open = 1'b0;
        span_t = 0;
        span_h = 0;
        span_w = 0;
        at_t = 0;
        at_h = 0;
        at_w = 0;
      end
      default: begin
        if (req == REQ_PROMPT && span_open) begin
          sum = longint'(pos_base) + run_len;
          hit = sum > POS_MAX;
          b = clamp_pos(sum);
          sum = longint'(b) + at_t;
          hit |= sum > POS_MAX;
          r.pos_t = clamp_pos(sum);
          sum = longint'(b) + at_h;
          hit |= sum > POS_MAX;
          r.pos_h = clamp_pos(sum);
          sum = longint'(b) + at_w;
          hit |= sum > POS_MAX;
          r.pos_w = clamp_pos(sum);
          r.is_visual = 1'b1;
          r.status = hit ? ST_SATURATED : ST_OK;
          // Column counter runs fastest, then row, then time.
          at_w++;
          if (at_w >= span_w) begin
            at_w = 0;
            at_h++;
            if (at_h >= span_h) begin
              at_h = 0;
              at_t++;
            end
          end
          if (at_t >= span_t) close_span();
        end else begin
          // A generated token abandons an open span before it is numbered as text.
          if (req == REQ_GEN && span_open) close_span();
          sum = longint'(pos_base) + run_len;
          hit = sum > POS_MAX;
          b = clamp_pos(sum);
          run_len = clamp_pos(longint'(run_len) + 1);
          r.status = ST_OK;
          if (req == REQ_PROMPT && tok == cfg_vs_id) begin
            if (gq_count == 0) begin
              r.status = ST_NO_GRID;
            end else begin
              span_t = gq_mem[gq_head].t;
              span_h = gq_mem[gq_head].h >> cfg_shift;
              span_w = gq_mem[gq_head].w >> cfg_shift;
              gq_head = (gq_head + 1) % QUEUE_DEPTH;
              gq_count--;
              at_t = 0;
              at_h = 0;
              at_w = 0;
              if (span_t == 0 || span_h == 0 || span_w == 0) close_span();
              else span_open = 1'b1;
            end
          end
          if (r.status == ST_OK && hit) r.status = ST_SATURATED;
          r.pos_t = b;
          r.pos_h = b;
          r.pos_w = b;
        end
        predicted_positions.insert(predicted_positions.size(), r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: handshakes, prediction, result checks and the stall watchdog.
  always @(posedge clk) begin
    result_t want;
    grid_t g;
    in_fire  = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    cfg_fire = rst_n && cfg_valid && cfg_ready;
    if (out_fire) begin
      if (predicted_positions.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual t=%0d h=%0d w=%0d vis=%0d st=%0d",
                 $time, out_pos_t, out_pos_h, out_pos_w, out_is_visual, out_status);
      end else begin
        want = predicted_positions.pop_front();
        check_field("pos_t", 32'(want.pos_t), 32'(out_pos_t));
        check_field("pos_h", 32'(want.pos_h), 32'(out_pos_h));
        check_field("pos_w", 32'(want.pos_w), 32'(out_pos_w));
        check_field("is_visual", 32'(want.is_visual), 32'(out_is_visual));
        check_field("status", 32'(want.status), 32'(out_status));
      end
    end
    if (cfg_fire) begin
      case (cfg_index)
        CFG_VISION_START_ID: cfg_vs_id = cfg_data;
        CFG_MERGE_SHIFT:     cfg_shift = cfg_data[MSHIFT_W-1:0];
        default: ;
      endcase
    end
    if (in_fire) begin
      g.t = in_grid_t;
      g.h = in_grid_h;
      g.w = in_grid_w;
      predict_positions(in_req_type, in_token_id, g);
    end
    if (!rst_n || in_fire || out_fire || cfg_fire) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Driver: offers the next queued request once the previous transaction is done.
  always @(negedge clk) begin
    token_req_t item;
    if (rst_n && (!in_valid || in_fire)) begin
      if (queued_requests.size() != 0 && !(jitter_on && $urandom_range(99) < 11)) begin
        item = queued_requests.pop_front();
        in_valid    <= 1'b1;
        in_req_type <= item.req;
        in_token_id <= item.tok;
        in_grid_t   <= item.grid.t;
        in_grid_h   <= item.grid.h;
        in_grid_w   <= item.grid.w;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink, with one long hold-off when the stall phase begins.
  always @(negedge clk) begin
    if (stall_phase && rx_hold_cnt < RX_HOLD_CYCLES) begin
      out_ready <= 1'b0;
      rx_hold_cnt++;
    end else begin
      out_ready <= !(jitter_on && $urandom_range(99) < 11);
    end
  end

  function automatic grid_t rand_grid(input bit big);
    grid_t g;
    g.t = GT_W'($urandom_range(1, 4));
    if (big) begin
      g.h = GHW_W'($urandom_range(1, 1023));
      g.w = GHW_W'($urandom_range(1, 1023));
    end else begin
      // Small grids, some of them merging down to an empty span.
      g.h = GHW_W'($urandom_range(1, 6 << plan_shift));
      g.w = GHW_W'($urandom_range(1, 6 << plan_shift));
    end
    return g;
  endfunction

  function automatic logic [TOKEN_W-1:0] plain_tok();
    logic [TOKEN_W-1:0] v;
    do v = TOKEN_W'($urandom); while (v == plan_vs_id);
    return v;
  endfunction

  task automatic add_item(input req_e_t req, input logic [TOKEN_W-1:0] tok, input grid_t g);
    token_req_t item;
    item.req = req;
    item.tok = tok;
    item.grid = g;
    queued_requests.insert(queued_requests.size(), item);
    if (req == REQ_PUSH && plan_grids.size() < QUEUE_DEPTH)
      plan_grids.insert(plan_grids.size(), g);
  endtask

  // Sends a vision start token and returns how many visual tokens its grid spans.
  task automatic open_image(output int unsigned len);
    grid_t g;
    add_item(REQ_PROMPT, plan_vs_id, rand_grid(1'b1));
    len = 0;
    if (plan_grids.size() != 0) begin
      g = plan_grids.pop_front();
      len = g.t * (g.h >> plan_shift) * (g.w >> plan_shift);
    end
  endtask

  task automatic plan_scenario();
    int unsigned pick, n, len, cut;
    req_e_t r;
    pick = $urandom_range(99);
    if (pick < 35) begin
      n = (plan_grids.size() == 0) ? 1 : $urandom_range(0, 2);
      repeat (n) add_item(REQ_PUSH, TOKEN_W'($urandom), rand_grid($urandom_range(9) == 0));
      open_image(len);
      if (len > 24 || $urandom_range(4) == 0) begin
        if (len != 0) begin
          cut = $urandom_range(0, (len > 8) ? 8 : len - 1);
          repeat (cut) add_item(REQ_PROMPT, TOKEN_W'($urandom), rand_grid(1'b1));
          add_item($urandom_range(1) ? REQ_GEN : REQ_NEW_SEQ, TOKEN_W'($urandom),
                   rand_grid(1'b1));
        end
      end else begin
        repeat (len) begin
          if ($urandom_range(19) == 0)
            add_item(REQ_PUSH, TOKEN_W'($urandom), rand_grid(1'b0));
          add_item(REQ_PROMPT, TOKEN_W'($urandom), rand_grid(1'b1));
        end
      end
    end else if (pick < 65) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(3) == 0) add_item(REQ_GEN, TOKEN_W'($urandom), rand_grid(1'b1));
        else add_item(REQ_PROMPT, plain_tok(), rand_grid(1'b1));
      end
    end else if (pick < 75) begin
      repeat ($urandom_range(1, 20))
        add_item(REQ_PUSH, TOKEN_W'($urandom), rand_grid($urandom_range(3) == 0));
    end else if (pick < 80) begin
      add_item(REQ_NEW_SEQ, TOKEN_W'($urandom), rand_grid(1'b1));
    end else begin
      // Loose requests of any kind; they never open a span.
      repeat ($urandom_range(1, 4)) begin
        r = req_e_t'($urandom_range(3));
        add_item(r, (r == REQ_PROMPT) ? plain_tok() : TOKEN_W'($urandom), rand_grid(1'b1));
      end
    end
  endtask

  task automatic plan_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = queued_requests.size() + count;
    while (queued_requests.size() < stop_at) plan_scenario();
  endtask

  task automatic wait_drained();
    while (queued_requests.size() != 0 || in_valid || predicted_positions.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_e_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_VISION_START_ID) plan_vs_id = data;
    else plan_shift = data[MSHIFT_W-1:0];
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  initial begin
    grid_t g;
    int unsigned len;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    write_cfg(CFG_VISION_START_ID, 18'h15A5A);
    write_cfg(CFG_MERGE_SHIFT, 18'd1);
    add_item(REQ_PROMPT, '0, rand_grid(1'b1));
    add_item(REQ_PROMPT, '1, rand_grid(1'b1));
    add_item(REQ_GEN, plan_vs_id, rand_grid(1'b1));
    add_item(REQ_PROMPT, plan_vs_id, rand_grid(1'b1));   // empty queue
    g = '{t: 3'd2, h: 10'd4, w: 10'd6};
    add_item(REQ_PUSH, '0, g);
    g = '{t: 3'd1, h: 10'd1, w: 10'd1023};               // row count merges to zero
    add_item(REQ_PUSH, '0, g);
    g = '{t: 3'd3, h: 10'd5, w: 10'd2};
    add_item(REQ_PUSH, '0, g);
    g = '{t: 3'd4, h: 10'd1023, w: 10'd2};
    add_item(REQ_PUSH, '1, g);
    open_image(len);
    add_item(REQ_PROMPT, plan_vs_id, rand_grid(1'b1));
    add_item(REQ_PROMPT, '0, rand_grid(1'b1));
    add_item(REQ_PROMPT, '1, rand_grid(1'b1));
    repeat (len - 3) add_item(REQ_PROMPT, TOKEN_W'($urandom), rand_grid(1'b1));
    open_image(len);
    open_image(len);
    add_item(REQ_PROMPT, TOKEN_W'($urandom), rand_grid(1'b1));
    add_item(REQ_GEN, TOKEN_W'($urandom), rand_grid(1'b1));   // abandons the span
    open_image(len);
    add_item(REQ_PROMPT, TOKEN_W'($urandom), rand_grid(1'b1));
    add_item(REQ_NEW_SEQ, '0, rand_grid(1'b1));
    add_item(REQ_PROMPT, '0, rand_grid(1'b1));
    wait_drained();

    write_cfg(CFG_VISION_START_ID, 18'h3FFFF);
    write_cfg(CFG_MERGE_SHIFT, 18'd3);
    plan_random(400);
    wait_drained();

    // No idling on either side, and one long hold-off on the result side.
    jitter_on = 1'b0;
    stall_phase = 1'b1;
    write_cfg(CFG_VISION_START_ID, 18'h0);
    write_cfg(CFG_MERGE_SHIFT, 18'd0);
    plan_random(400);
    wait_drained();
    jitter_on = 1'b1;

    // Large abandoned spans move the base up in big steps.
    write_cfg(CFG_VISION_START_ID, 18'h2B3C1);
    repeat (200) begin
      g = '{t: GT_W'($urandom_range(1, 4)), h: 10'd1023, w: 10'd1023};
      add_item(REQ_PUSH, TOKEN_W'($urandom), g);
      open_image(len);
      if (len != 0) add_item(REQ_GEN, TOKEN_W'($urandom), rand_grid(1'b1));
    end
    plan_random(60);
    add_item(REQ_NEW_SEQ, TOKEN_W'($urandom), rand_grid(1'b1));
    wait_drained();

    write_cfg(CFG_VISION_START_ID, CFG_DATA_W'($urandom));
    write_cfg(CFG_MERGE_SHIFT, 18'd2);
    plan_random(120);
    wait_drained();

    if (mismatches == 0 && predicted_positions.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: mrope_position_id_generator_top.f
rtl/mrope_pkg.sv
rtl/mrope_ram.sv
rtl/mrope_out_buf.sv
rtl/mrope_position_id_generator_top.sv
sim/mrope_position_id_generator_top_tb.sv
